[rtl/core/hbridge_speed_ramp_controller_top_assert.svh]
// Assertion macros for the H-bridge speed ramp controller.
// Both macros sample on the rising edge of clock; the first one is muted during reset.
`ifndef HBRIDGE_SPEED_RAMP_CONTROLLER_TOP_ASSERT_SVH
`define HBRIDGE_SPEED_RAMP_CONTROLLER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define HSRC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hsrc assertion failed");

`define HSRC_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("hsrc reset assertion failed");

`else

`define HSRC_ASSERT(label, prop)

`define HSRC_ASSERT_RST(label, prop)

`endif

`endif

[rtl/core/hsrc_pkg.sv]
`default_nettype none

package hsrc_pkg;

   localparam int SPEED_W    = 9;
   localparam int DUTY_W     = 8;
   localparam int TEMP_W     = 12;
   localparam int ACTION_W   = 3;
   localparam int CFG_BYTE_W = 8;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   // largest magnitude the 8-bit duty outputs can carry
   localparam int DUTY_CAP = (1 << DUTY_W) - 1;

   localparam int MAX_DUTY_DEF  = 255;
   localparam int TEMP_BITS_DEF = 12;

   localparam logic [CFG_BYTE_W-1:0] MAX_SPEED_RST  = 8'd255;
   localparam logic [CFG_BYTE_W-1:0] ACCEL_STEP_RST = 8'd5;
   localparam logic [TEMP_W-1:0]     TEMP_LIMIT_RST = 12'd3000;
   localparam logic [TEMP_W-1:0]     TEMP_HYS_RST   = 12'd100;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK      = 3'd0,
      ACT_SET_SPEED = 3'd1,
      ACT_START     = 3'd2,
      ACT_STOP      = 3'd3,
      ACT_ESTOP     = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_SPEED  = 2'd0,
      CSR_ACCEL_STEP = 2'd1,
      CSR_TEMP_LIMIT = 2'd2,
      CSR_TEMP_HYS   = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

[rtl/core/hsrc_req_if.sv]
`default_nettype none

interface hsrc_req_if;
   import hsrc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [TEMP_W-1:0]          temperature;
   logic signed [SPEED_W-1:0]  speed_request;

   modport source (output valid, output action, output temperature, output speed_request,
                   input ready);
   modport sink   (input valid, input action, input temperature, input speed_request,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/hsrc_rsp_if.sv]
`default_nettype none

interface hsrc_rsp_if;
   import hsrc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [DUTY_W-1:0]          forward_duty;
   logic [DUTY_W-1:0]          reverse_duty;
   logic                       bridge_enable;
   logic signed [SPEED_W-1:0]  current_speed;
   logic                       over_temp;
   logic                       running;

   modport source (output valid, output forward_duty, output reverse_duty,
                   output bridge_enable, output current_speed, output over_temp,
                   output running, input ready);
   modport sink   (input valid, input forward_duty, input reverse_duty,
                   input bridge_enable, input current_speed, input over_temp,
                   input running, output ready);
endinterface

`default_nettype wire

[rtl/core/hbridge_speed_ramp_controller_top.sv]
// H-bridge speed ramp controller. Each command item (tick with a temperature sample, set
// speed, start, stop, emergency stop) yields exactly one status item with the split
// forward/reverse duties, the signed actual speed, and the enable, over-temperature and
// run flags. An accepted item is held in the input register, and its status is
// registered into the output register as the item advances, so one item is
// taken every cycle; the only limit is the output register, which frees as soon as the
// sink takes its item. Configuration writes go straight to the registers and are meant
// for idle periods. The actual speed slews by accel_step per tick and saturates at
// plus or minus min(MAX_DUTY, 255).
`default_nettype none

`include "hbridge_speed_ramp_controller_top_assert.svh"

module hbridge_speed_ramp_controller_top #(
   parameter int MAX_DUTY  = hsrc_pkg::MAX_DUTY_DEF,
   parameter int TEMP_BITS = hsrc_pkg::TEMP_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   hsrc_req_if.sink                              req_ch,
   hsrc_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [hsrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [hsrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hsrc_pkg::*;

   localparam int DUTY_LIM = (MAX_DUTY < DUTY_CAP) ? MAX_DUTY : DUTY_CAP;
   localparam int TW       = (TEMP_BITS < TEMP_W) ? TEMP_BITS : TEMP_W;
   localparam int WIDE_W   = SPEED_W + 2;

   localparam logic signed [WIDE_W-1:0] LIM_POS = WIDE_W'(DUTY_LIM);
   localparam logic signed [WIDE_W-1:0] LIM_NEG = -LIM_POS;

   // configuration registers
   logic [CFG_BYTE_W-1:0]       max_speed_ff;
   logic [CFG_BYTE_W-1:0]       accel_step_ff;
   logic [TEMP_W-1:0]           temp_limit_ff;
   logic [TEMP_W-1:0]           temp_hys_ff;

   // input register
   logic                        s1_valid_ff, s1_valid_in;
   action_type                  s1_action_ff;
   logic [TEMP_W-1:0]           s1_temp_ff;
   logic signed [SPEED_W-1:0]   s1_req_ff;

   // controller state
   logic signed [SPEED_W-1:0]   actual_ff, actual_in;
   logic signed [SPEED_W-1:0]   target_ff, target_in;
   logic signed [SPEED_W-1:0]   request_ff, request_in;
   logic                        run_ff, run_in;
   logic                        estop_ff, estop_in;
   logic                        enable_ff, enable_in;
   logic                        fault_ff, fault_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]           rsp_fwd_ff, rsp_fwd_in;
   logic [DUTY_W-1:0]           rsp_rev_ff, rsp_rev_in;

   logic                        req_take;
   logic                        rsp_free;
   logic                        s1_go;

   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go         = s1_valid_ff && rsp_free;
   assign req_ch.ready  = !s1_valid_ff || rsp_free;
   assign req_take      = req_ch.valid && req_ch.ready;

   assign s1_valid_in   = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in  = s1_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // command decode, fault hysteresis and slew
   always_comb begin
      logic [TW-1:0]               t_s;
      logic [TW-1:0]               lim_s;
      logic [TW-1:0]               hys_s;
      logic [TW:0]                 clear_sum;
      logic signed [SPEED_W-1:0]   ms;
      logic signed [SPEED_W:0]     diff;
      logic [SPEED_W:0]            mag;
      logic signed [WIDE_W-1:0]    base;
      logic signed [WIDE_W-1:0]    stepx;
      logic signed [WIDE_W-1:0]    moved;
      logic signed [SPEED_W-1:0]   neg_actual;

      actual_in  = actual_ff;
      target_in  = target_ff;
      request_in = request_ff;
      run_in     = run_ff;
      estop_in   = estop_ff;
      enable_in  = enable_ff;
      fault_in   = fault_ff;

      t_s       = s1_temp_ff[TW-1:0];
      lim_s     = temp_limit_ff[TW-1:0];
      hys_s     = temp_hys_ff[TW-1:0];
      clear_sum = {1'b0, t_s} + {1'b0, hys_s};
      ms        = signed'({1'b0, max_speed_ff});
      diff      = '0;
      mag       = '0;
      base      = '0;
      stepx     = '0;
      moved     = '0;

      unique case (s1_action_ff)
         ACT_TICK: begin
            if (t_s >= lim_s) begin
               fault_in = 1'b1;
            end else if (clear_sum <= {1'b0, lim_s}) begin
               fault_in = 1'b0;
            end

            if (fault_in) begin
               run_in    = 1'b0;
               target_in = '0;
            end else if (run_ff) begin
               target_in = request_ff;
            end else if (!estop_ff && actual_ff == '0) begin
               enable_in = 1'b0;
            end

            diff  = {target_in[SPEED_W-1], target_in} - {actual_ff[SPEED_W-1], actual_ff};
            mag   = diff[SPEED_W] ? $unsigned(-diff) : $unsigned(diff);
            base  = WIDE_W'(actual_ff);
            stepx = signed'({3'b000, accel_step_ff});
            if (mag < {2'b00, accel_step_ff}) begin
               moved = WIDE_W'(target_in);
            end else if (target_in >= actual_ff) begin
               moved = base + stepx;
            end else begin
               moved = base - stepx;
            end
            // saturate to the duty limit
            if (moved > LIM_POS) begin
               moved = LIM_POS;
            end else if (moved < LIM_NEG) begin
               moved = LIM_NEG;
            end
            actual_in = signed'(moved[SPEED_W-1:0]);
         end
         ACT_SET_SPEED: begin
            if (s1_req_ff > ms) begin
               request_in = ms;
            end else if (s1_req_ff < -ms) begin
               request_in = -ms;
            end else begin
               request_in = s1_req_ff;
            end
         end
         ACT_START: begin
            run_in    = 1'b1;
            estop_in  = 1'b0;
            enable_in = 1'b1;
         end
         ACT_STOP: begin
            run_in    = 1'b0;
            target_in = '0;
         end
         ACT_ESTOP: begin
            actual_in = '0;
            target_in = '0;
            run_in    = 1'b0;
            estop_in  = 1'b1;
         end
         default: begin
            // unknown command: report status only
         end
      endcase

      neg_actual = -actual_in;
      rsp_fwd_in = actual_in[SPEED_W-1] ? '0 : actual_in[DUTY_W-1:0];
      rsp_rev_in = actual_in[SPEED_W-1] ? neg_actual[DUTY_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= MAX_SPEED_RST;
         accel_step_ff <= ACCEL_STEP_RST;
         temp_limit_ff <= TEMP_LIMIT_RST;
         temp_hys_ff   <= TEMP_HYS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[CFG_BYTE_W-1:0];
            CSR_ACCEL_STEP: accel_step_ff <= csr_wdata[CFG_BYTE_W-1:0];
            CSR_TEMP_LIMIT: temp_limit_ff <= csr_wdata[TEMP_W-1:0];
            CSR_TEMP_HYS:   temp_hys_ff   <= csr_wdata[TEMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         actual_ff    <= '0;
         target_ff    <= '0;
         request_ff   <= '0;
         run_ff       <= 1'b0;
         estop_ff     <= 1'b0;
         enable_ff    <= 1'b0;
         fault_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            actual_ff  <= actual_in;
            target_ff  <= target_in;
            request_ff <= request_in;
            run_ff     <= run_in;
            estop_ff   <= estop_in;
            enable_ff  <= enable_in;
            fault_ff   <= fault_in;
         end
      end
   end

   // payload registers: load the item on accept, the status on advance
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= action_type'(req_ch.action);
         s1_temp_ff   <= req_ch.temperature;
         s1_req_ff    <= req_ch.speed_request;
      end
      if (s1_go) begin
         rsp_fwd_ff <= rsp_fwd_in;
         rsp_rev_ff <= rsp_rev_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.forward_duty  = rsp_fwd_ff;
   assign rsp_ch.reverse_duty  = rsp_rev_ff;
   assign rsp_ch.bridge_enable = enable_ff;
   assign rsp_ch.current_speed = actual_ff;
   assign rsp_ch.over_temp     = fault_ff;
   assign rsp_ch.running       = run_ff;

   `HSRC_ASSERT(a_duty_one_leg, rsp_valid_ff |-> (rsp_fwd_ff == '0 || rsp_rev_ff == '0))
   `HSRC_ASSERT(a_speed_in_range, (WIDE_W'(actual_ff) <= LIM_POS && WIDE_W'(actual_ff) >= LIM_NEG))
   `HSRC_ASSERT(a_fault_stops, (s1_go && s1_action_ff == ACT_TICK && fault_in) |=> (!run_ff && target_ff == '0))
   `HSRC_ASSERT(a_estop_zero, (s1_go && s1_action_ff == ACT_ESTOP) |=> (actual_ff == '0 && estop_ff && !run_ff))
   `HSRC_ASSERT(a_duty_tracks_speed, s1_go |=> (rsp_fwd_ff == (actual_ff[SPEED_W-1] ? '0 : actual_ff[DUTY_W-1:0])))
   `HSRC_ASSERT_RST(a_reset_idle, reset |=> (!run_ff && !enable_ff && !rsp_valid_ff && actual_ff == '0))

endmodule

`default_nettype wire
